// File: rtl/srtw_pkg.sv
// ----------------------------------------------------------------------------
// srtw_pkg
// Shared constants, types and the threshold ladder for the symbol rate to
// timing word converter.
// ----------------------------------------------------------------------------
package srtw_pkg;

    localparam int RATE_W       = 23;   // clamped rate fits below 2^23
    localparam int NUM_W        = 30;   // numerator of the inverse word
    localparam int DIV_BITS     = 9;    // inverse quotient stays below 512
    localparam int REM_W        = RATE_W;
    localparam int DEC_W        = 2;
    localparam int WORD_W       = 21;
    localparam int INV_W        = 8;
    localparam int EST_W        = 22;   // rate word estimate, up to 2^21
    localparam int RECIP_W      = 22;
    localparam int RECIP_SHIFT  = 23;
    localparam int WORD_SHIFT   = 17;   // 2^24 / 57840000 == 2^17 / 451875
    localparam int DIVISOR_W    = 19;
    localparam int PROD_W       = RATE_W + RECIP_W;
    localparam int CHK_W        = EST_W + DIVISOR_W;
    localparam int SCALED_W     = RATE_W + WORD_SHIFT;

    localparam int FRONT_STAGES = 3;
    localparam int WORD_STAGES  = 3;
    localparam int WORD_DELAY   = DIV_BITS - WORD_STAGES;
    localparam int PIPE_LATENCY = FRONT_STAGES + DIV_BITS;

    localparam logic [RATE_W-1:0]    RATE_MIN = 23'd870000;
    localparam logic [RATE_W-1:0]    RATE_MAX = 23'd7230000;
    localparam logic [NUM_W-1:0]     INV_NUM  = 30'd925440000;
    localparam logic [DIVISOR_W-1:0] SYS_DIV  = 19'd451875;
    localparam logic [RECIP_W-1:0]   RECIP    = 22'((64'd1 << 40) / 64'd451875);
    localparam logic [WORD_W-1:0]    WORD_MAX = 21'h1FFFFF;
    localparam logic [INV_W-1:0]     INV_SAT  = 8'hFF;

    typedef logic [RATE_W-1:0] rate_t;

    typedef struct packed {
        logic [DEC_W-1:0] dec;
        logic             filt;
    } ladder_t;

    // one restoring division step's working set
    typedef struct packed {
        logic [REM_W-1:0]    rem;
        logic [DIV_BITS-1:0] low;
        rate_t               den;
        logic [DIV_BITS-1:0] quo;
    } div_stage_t;

    typedef struct packed {
        ladder_t lad;
        rate_t   x;      // rate scaled by 2^dec
    } side_t;

    typedef struct packed {
        ladder_t           lad;
        logic [WORD_W-1:0] word;
    } word_t;

    function automatic ladder_t ladder_lookup(rate_t r);
        ladder_t res;
        if (r < 23'd587804)       res = '{dec: 2'd3, filt: 1'b1};
        else if (r < 23'd903750)  res = '{dec: 2'd3, filt: 1'b0};
        else if (r < 23'd1175609) res = '{dec: 2'd2, filt: 1'b1};
        else if (r < 23'd1807500) res = '{dec: 2'd2, filt: 1'b0};
        else if (r < 23'd2351219) res = '{dec: 2'd1, filt: 1'b1};
        else if (r < 23'd3615000) res = '{dec: 2'd1, filt: 1'b0};
        else if (r < 23'd4702439) res = '{dec: 2'd0, filt: 1'b1};
        else                      res = '{dec: 2'd0, filt: 1'b0};
        return res;
    endfunction

endpackage

// File: rtl/srtw_front.sv
// ----------------------------------------------------------------------------
// srtw_front
// Clamp, ladder lookup and operand preparation: three register stages.
// ----------------------------------------------------------------------------
module srtw_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [31:0]                 requested_rate,
    output logic                        out_valid,
    output srtw_pkg::div_stage_t        out_div,
    output srtw_pkg::side_t             out_side
);

    logic                   a_valid_reg, b_valid_reg, c_valid_reg;
    srtw_pkg::rate_t        a_rate_reg, a_rate_next;
    srtw_pkg::rate_t        b_rate_reg;
    srtw_pkg::ladder_t      b_lad_reg, b_lad_next;
    srtw_pkg::div_stage_t   c_div_reg, c_div_next;
    srtw_pkg::side_t        c_side_reg, c_side_next;

    logic [srtw_pkg::NUM_W-1:0]    num;
    logic [srtw_pkg::RATE_W+2:0]   x_wide;

    always_comb
    begin
        if (requested_rate > {9'd0, srtw_pkg::RATE_MAX})
            a_rate_next = srtw_pkg::RATE_MAX;
        else if (requested_rate < {9'd0, srtw_pkg::RATE_MIN})
            a_rate_next = srtw_pkg::RATE_MIN;
        else
            a_rate_next = requested_rate[srtw_pkg::RATE_W-1:0];
    end

    assign b_lad_next = srtw_pkg::ladder_lookup(a_rate_reg);

    always_comb
    begin
        num = (srtw_pkg::INV_NUM >> b_lad_reg.dec)
            + {{(srtw_pkg::NUM_W-srtw_pkg::RATE_W+1){1'b0}},
               b_rate_reg[srtw_pkg::RATE_W-1:1]};
        // rate << dec stays at or below 7230000 on every rung
        x_wide = {3'b000, b_rate_reg} << b_lad_reg.dec;

        c_div_next.rem = srtw_pkg::REM_W'(num >> srtw_pkg::DIV_BITS);
        c_div_next.low = num[srtw_pkg::DIV_BITS-1:0];
        c_div_next.den = b_rate_reg;
        c_div_next.quo = '0;

        c_side_next.lad = b_lad_reg;
        c_side_next.x   = x_wide[srtw_pkg::RATE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_rate_reg <= a_rate_next;
        b_rate_reg <= a_rate_reg;
        b_lad_reg  <= b_lad_next;
        c_div_reg  <= c_div_next;
        c_side_reg <= c_side_next;
    end

    assign out_valid = c_valid_reg;
    assign out_div   = c_div_reg;
    assign out_side  = c_side_reg;

endmodule

// File: rtl/srtw_div_step.sv
// ----------------------------------------------------------------------------
// srtw_div_step
// One registered restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module srtw_div_step (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  srtw_pkg::div_stage_t    in_stage,
    output logic                    out_valid,
    output srtw_pkg::div_stage_t    out_stage
);

    logic                           valid_reg;
    srtw_pkg::div_stage_t           stage_reg, stage_next;
    logic [srtw_pkg::REM_W:0]       trial;
    logic [srtw_pkg::REM_W:0]       diff;
    logic                           fits;

    always_comb
    begin
        // bring down the next numerator bit
        trial = {in_stage.rem, in_stage.low[srtw_pkg::DIV_BITS-1]};
        diff  = trial - {1'b0, in_stage.den};
        fits  = (trial >= {1'b0, in_stage.den});

        stage_next.rem = fits ? diff[srtw_pkg::REM_W-1:0] : trial[srtw_pkg::REM_W-1:0];
        stage_next.low = {in_stage.low[srtw_pkg::DIV_BITS-2:0], 1'b0};
        stage_next.den = in_stage.den;
        stage_next.quo = {in_stage.quo[srtw_pkg::DIV_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        stage_reg <= stage_next;
    end

    assign out_valid = valid_reg;
    assign out_stage = stage_reg;

endmodule

// File: rtl/srtw_rate_word.sv
// ----------------------------------------------------------------------------
// srtw_rate_word
// Rate word by reciprocal multiply with one correction step, then a delay
// line that lines it up with the end of the divider chain.
// ----------------------------------------------------------------------------
module srtw_rate_word (
    input  logic                clk,
    input  srtw_pkg::side_t     in_side,
    output srtw_pkg::word_t     out_word
);

    logic [srtw_pkg::PROD_W-1:0]    prod;
    logic [srtw_pkg::EST_W-1:0]     e1_est_reg, e2_est_reg;
    srtw_pkg::side_t                e1_side_reg, e2_side_reg;
    logic [srtw_pkg::CHK_W-1:0]     chk;
    logic [srtw_pkg::CHK_W-1:0]     e2_chk_reg;
    logic [srtw_pkg::SCALED_W-1:0]  remain;
    logic [srtw_pkg::EST_W-1:0]     fixed;
    srtw_pkg::word_t                w3_next;
    srtw_pkg::word_t                line_reg [srtw_pkg::WORD_DELAY+1];

    // estimate is exact or one low
    assign prod = {{srtw_pkg::RECIP_W{1'b0}}, in_side.x}
                * {{srtw_pkg::RATE_W{1'b0}}, srtw_pkg::RECIP};

    assign chk = {{srtw_pkg::DIVISOR_W{1'b0}}, e1_est_reg}
               * {{srtw_pkg::EST_W{1'b0}}, srtw_pkg::SYS_DIV};

    always_comb
    begin
        remain = {e2_side_reg.x, {srtw_pkg::WORD_SHIFT{1'b0}}}
               - e2_chk_reg[srtw_pkg::SCALED_W-1:0];
        fixed  = e2_est_reg
               + srtw_pkg::EST_W'(remain >= srtw_pkg::SCALED_W'(srtw_pkg::SYS_DIV));
        w3_next.lad  = e2_side_reg.lad;
        w3_next.word = fixed[srtw_pkg::WORD_W] ? srtw_pkg::WORD_MAX
                                               : fixed[srtw_pkg::WORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        e1_est_reg  <= prod[srtw_pkg::PROD_W-1:srtw_pkg::RECIP_SHIFT];
        e1_side_reg <= in_side;
        e2_est_reg  <= e1_est_reg;
        e2_chk_reg  <= chk;
        e2_side_reg <= e1_side_reg;
        line_reg[0] <= w3_next;
        for (int i = 1; i <= srtw_pkg::WORD_DELAY; i++)
        begin
            line_reg[i] <= line_reg[i-1];
        end
    end

    assign out_word = line_reg[srtw_pkg::WORD_DELAY];

endmodule

// File: rtl/symbol_rate_to_timing_words_top.sv
// ----------------------------------------------------------------------------
// symbol_rate_to_timing_words_top
// Symbol rate to demodulator timing words for a 57.84 MHz system clock.
// ----------------------------------------------------------------------------
//
//   channel   handshake           payload
//   -------   -----------------   ------------------------------------------
//   request   start / busy        requested_rate
//   result    done (strobe)       decimation, filter_enable, rate_word,
//                                 inverse_rate
//
// A request is taken in every cycle; busy stays low.
// Each result passes through three front stages (clamp, ladder, operand setup)
// and nine divider stages, one quotient bit each.
// The rate word runs beside the divider in two multiply stages and a correction
// stage, then a delay line.
// Reset clears the valid bits only; results are never held off by the receiver.
//
module symbol_rate_to_timing_words_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] requested_rate,
    output logic        done,
    output logic [1:0]  decimation,
    output logic        filter_enable,
    output logic [20:0] rate_word,
    output logic [7:0]  inverse_rate
);

    logic                   chain_valid [srtw_pkg::DIV_BITS+1];
    srtw_pkg::div_stage_t   chain_stage [srtw_pkg::DIV_BITS+1];
    srtw_pkg::side_t        side;
    srtw_pkg::word_t        word;
    srtw_pkg::div_stage_t   last;

    assign busy = 1'b0;

    srtw_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start && !busy),
        .requested_rate (requested_rate),
        .out_valid      (chain_valid[0]),
        .out_div        (chain_stage[0]),
        .out_side       (side)
    );

    for (genvar g = 0; g < srtw_pkg::DIV_BITS; g++)
    begin : g_div
        srtw_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[g]),
            .in_stage  (chain_stage[g]),
            .out_valid (chain_valid[g+1]),
            .out_stage (chain_stage[g+1])
        );
    end

    srtw_rate_word u_word (
        .clk      (clk),
        .in_side  (side),
        .out_word (word)
    );

    assign last          = chain_stage[srtw_pkg::DIV_BITS];
    assign done          = chain_valid[srtw_pkg::DIV_BITS];
    assign decimation    = word.lad.dec;
    assign filter_enable = word.lad.filt;
    assign rate_word     = word.word;
    // quotient top bit means the inverse is past 255
    assign inverse_rate  = last.quo[srtw_pkg::DIV_BITS-1] ? srtw_pkg::INV_SAT
                                                          : last.quo[srtw_pkg::INV_W-1:0];

endmodule

// File: rtl/srtw_checker.sv
// ----------------------------------------------------------------------------
// srtw_checker
// Port-level checks on the timing word converter, bound to the top level.
// ----------------------------------------------------------------------------
module srtw_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        done,
    input  logic [1:0]  decimation,
    input  logic        filter_enable,
    input  logic [7:0]  inverse_rate
);

    // no request is ever refused
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    // every result traces back to a request a fixed latency earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, srtw_pkg::PIPE_LATENCY))
        else $error("result without matching request");

    // lowest rung is unreachable after the clamp
    a_no_low_rung: assert property (@(posedge clk) disable iff (!rst_n)
        (done && decimation == 2'd3) |-> !filter_enable)
        else $error("lowest ladder rung selected");

    // inverse word stays in its upper half over the whole clamped range
    a_inv_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> inverse_rate[7])
        else $error("inverse word below 128");

endmodule

bind symbol_rate_to_timing_words_top srtw_checker u_srtw_checker (.*);
